>>> rtl/sbcr_pkg.sv
// ----------------------------------------------------------------------------
// sbcr_pkg
// Shared types, codes and constants of the swept box collision resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package sbcr_pkg;

  localparam int DW = 24;
  localparam int PW = 32;
  localparam int TW = 19;
  localparam int QB = 18;
  localparam int TOL_W = 16;
  localparam int CNT_W = 7;

  localparam int DEF_MAX_SOLIDS = 64;
  localparam int DEF_MAX_SWEEPS = 4;

  localparam logic signed [TW-1:0] T_ONE = 19'sd65536;
  localparam logic signed [TW-1:0] T_MIN = -19'sd262144;
  localparam logic signed [TW-1:0] T_MAX = 19'sd262143;

  localparam logic signed [PW-1:0] POS_HI = 32'sd8388607;
  localparam logic signed [PW-1:0] POS_LO = -32'sd8388608;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_MOVE  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_OVERLAP  = 2'd2;

  localparam logic [1:0] CFG_SOLID_COUNT = 2'd0;
  localparam logic [1:0] CFG_TIME_TOL    = 2'd1;
  localparam logic [1:0] CFG_GROUND_TOL  = 2'd2;

  typedef struct packed {
    logic        [1:0]    kind;
    logic        [5:0]    solid_index;
    logic signed [DW-1:0] rect_x;
    logic signed [DW-1:0] rect_y;
    logic signed [DW-1:0] rect_w;
    logic signed [DW-1:0] rect_h;
    logic signed [DW-1:0] move_dx;
    logic signed [DW-1:0] move_dy;
  } req_t;

  typedef struct packed {
    logic        [1:0]    status;
    logic signed [DW-1:0] new_x;
    logic signed [DW-1:0] new_y;
    logic                 hit_floor;
    logic                 hit_ceiling;
    logic                 hit_left_wall;
    logic                 hit_right_wall;
    logic                 grounded;
  } rsp_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] w;
    logic signed [DW-1:0] h;
  } solid_t;

  function automatic logic signed [DW-1:0] sat24(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = v;
    if (v > POS_HI) r = POS_HI;
    if (v < POS_LO) r = POS_LO;
    return r[DW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/sbcr_if.sv
// ----------------------------------------------------------------------------
// sbcr_req_if / sbcr_rsp_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbcr_req_if;
  logic            valid;
  logic            ready;
  sbcr_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbcr_rsp_if;
  logic            valid;
  logic            ready;
  sbcr_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/swept_box_collision_resolver.sv
// ----------------------------------------------------------------------------
// swept_box_collision_resolver
// Sweeps a body box against a table of solids, slides along contacts and
// answers ground support queries.
//
//   channel  dir  handshake        content
//   req      in   valid / ready    kind, index, box, displacement
//   rsp      out  valid / ready    status, position, contact flags
//   cfg      in   cfg_we           solid count, time and ground tolerance
//
// Query and overlap check: a fetch and an evaluate state per solid scanned.
// Move sweep: up to four divisions per solid on the single shared divider,
// plus the multiply, advance and end states of each sweep.
// req is ready only between transactions.
// A finished result waits in the output register until rsp is taken.
// Reset is synchronous; the solid table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_box_collision_resolver #(
  parameter int MAX_SOLIDS = sbcr_pkg::DEF_MAX_SOLIDS,
  parameter int MAX_SWEEPS = sbcr_pkg::DEF_MAX_SWEEPS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [sbcr_pkg::TOL_W-1:0] cfg_data,
  sbcr_req_if.sink                  req,
  sbcr_rsp_if.source                rsp
);
  import sbcr_pkg::*;

  localparam int AW = (MAX_SOLIDS > 1) ? $clog2(MAX_SOLIDS) : 1;
  localparam int CW = $clog2(MAX_SOLIDS + 1);
  localparam int SW = $clog2(MAX_SWEEPS + 1);
  localparam int UW = (CW > CNT_W) ? CW : CNT_W;
  localparam int IW = (AW > 6) ? AW + 1 : 7;
  localparam int ET = TW + 2;
  localparam int MW = DW + TW;

  typedef enum logic [4:0] {
    S_IDLE, S_OV_F, S_OV_E, S_GR_F, S_GR_E, S_SW, S_FETCH, S_XA, S_XW1,
    S_XW2, S_YA, S_YW1, S_YW2, S_EVAL, S_MUL_X, S_ADV_X, S_MUL_Y, S_ADV_Y,
    S_SW_END, S_DONE
  } state_t;

  state_t state;

  logic [CNT_W-1:0] solid_count;
  logic [TOL_W-1:0] time_tol;
  logic [TOL_W-1:0] ground_tol;

  logic [1:0]           status;
  logic signed [PW-1:0] px, py;
  logic signed [DW-1:0] bw, bh, rx, ry;
  logic [CW-1:0]        i;
  logic [SW-1:0]        s;
  logic                 fl, ce, lw, rw, gr;
  logic                 found;
  logic signed [TW-1:0] best;
  logic                 ff, fc, fle, fri, cf, cc, cle, cri;
  logic signed [TW-1:0] xe, xl, ye, yl, tmp_a;
  logic signed [MW-1:0] prod;
  logic                 out_valid;
  rsp_t                 out_data;

  solid_t               sol;
  solid_t               wsol;
  logic                 st_we;
  logic                 div_start, div_done;
  logic signed [PW-1:0] div_num;
  logic signed [DW-1:0] div_den;
  logic signed [TW-1:0] div_q;

  logic [UW-1:0]        cnt_ext, n_used;
  logic [CW-1:0]        n_cw;
  logic                 last, accept, bad, in_range;
  logic signed [PW-1:0] sx, sy, sxe, sye, bx1, by1, gdiff, gabs;
  logic                 ov_x, ov_y, feet;
  logic signed [ET-1:0] xe_e, xl_e, ye_e, yl_e, en_e, lv_e, tol_e, one_e;
  logic signed [ET-1:0] enc, best_e, dxy, adxy, dbe, adbe;
  logic                 miss, corner, take, merge;
  logic                 tf, tc, tl, tr;
  logic                 ofl, oce, olw, orw;
  logic signed [DW-1:0] mul_a;
  logic signed [MW-1:0] mul_p, prod_r;
  logic signed [DW-1:0] adv;

  sbcr_store #(.DEPTH(MAX_SOLIDS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (AW'(req.data.solid_index)),
    .wdata (wsol),
    .raddr (i[AW-1:0]),
    .rdata (sol)
  );

  sbcr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign accept    = req.valid && (state == S_IDLE);

  always_comb begin
    cnt_ext  = UW'(solid_count);
    n_used   = (cnt_ext > UW'(MAX_SOLIDS)) ? UW'(MAX_SOLIDS) : cnt_ext;
    n_cw     = n_used[CW-1:0];
    last     = (i + CW'(1)) == n_cw;
    bad      = (req.data.rect_w <= 0) || (req.data.rect_h <= 0);
    in_range = IW'(req.data.solid_index) < IW'(MAX_SOLIDS);
    st_we    = accept && (req.data.kind == KIND_LOAD) && !bad && in_range;
    wsol.x   = req.data.rect_x;
    wsol.y   = req.data.rect_y;
    wsol.w   = req.data.rect_w;
    wsol.h   = req.data.rect_h;

    sx    = PW'(sol.x);
    sy    = PW'(sol.y);
    sxe   = sx + PW'(sol.w);
    sye   = sy + PW'(sol.h);
    bx1   = px + PW'(bw);
    by1   = py + PW'(bh);
    ov_x  = (px < sxe) && (bx1 > sx);
    ov_y  = (py < sye) && (by1 > sy);
    gdiff = by1 - sy;
    gabs  = gdiff[PW-1] ? -gdiff : gdiff;
    feet  = gabs <= PW'({1'b0, ground_tol});

    case (state)
      S_XW1: begin
        div_num = sxe - px;
        div_den = rx;
      end
      S_YA: begin
        div_num = sy - by1;
        div_den = ry;
      end
      S_YW1: begin
        div_num = sye - py;
        div_den = ry;
      end
      default: begin
        div_num = sx - bx1;
        div_den = rx;
      end
    endcase
    div_start = ((state == S_XA) && (rx != 0)) || ((state == S_YA) && (ry != 0)) ||
                (((state == S_XW1) || (state == S_YW1)) && div_done);

    xe_e   = ET'(xe);
    xl_e   = ET'(xl);
    ye_e   = ET'(ye);
    yl_e   = ET'(yl);
    tol_e  = ET'({1'b0, time_tol});
    one_e  = ET'(T_ONE);
    best_e = ET'(best);
    en_e   = (xe_e > ye_e) ? xe_e : ye_e;
    lv_e   = (xl_e < yl_e) ? xl_e : yl_e;
    miss   = (en_e >= lv_e - tol_e) || (en_e < -tol_e) || (en_e > one_e + tol_e);
    enc    = en_e;
    if (en_e < 0) enc = '0;
    if (en_e > one_e) enc = one_e;
    dxy    = xe_e - ye_e;
    adxy   = dxy[ET-1] ? -dxy : dxy;
    corner = adxy <= tol_e;
    tr     = (corner || (xe_e > ye_e)) && (rx != 0) && !rx[DW-1];
    tl     = (corner || (xe_e > ye_e)) && rx[DW-1];
    tf     = (corner || (ye_e > xe_e)) && (ry != 0) && !ry[DW-1];
    tc     = (corner || (ye_e > xe_e)) && ry[DW-1];
    take   = !found || (enc < best_e - tol_e);
    dbe    = enc - best_e;
    adbe   = dbe[ET-1] ? -dbe : dbe;
    merge  = adbe <= tol_e;

    ofl = ff || (!(fle || fri) && cf);
    oce = fc || (!(fle || fri) && cc);
    olw = fle || (!(ff || fc) && cle);
    orw = fri || (!(ff || fc) && cri);

    mul_a  = (state == S_MUL_Y) ? ry : rx;
    mul_p  = mul_a * best;
    prod_r = prod + (prod[MW-1] ? MW'(16'hFFFF) : MW'(0));
    adv    = prod_r[DW+15:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      solid_count <= '0;
      time_tol    <= TOL_W'(66);
      ground_tol  <= TOL_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOLID_COUNT: solid_count <= cfg_data[CNT_W-1:0];
        CFG_TIME_TOL:    time_tol    <= cfg_data;
        CFG_GROUND_TOL:  ground_tol  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            px     <= PW'(req.data.rect_x);
            py     <= PW'(req.data.rect_y);
            bw     <= req.data.rect_w;
            bh     <= req.data.rect_h;
            rx     <= req.data.move_dx;
            ry     <= req.data.move_dy;
            status <= ST_OK;
            {fl, ce, lw, rw, gr} <= '0;
            i      <= '0;
            s      <= '0;
            state  <= S_DONE;
            case (req.data.kind)
              KIND_LOAD: begin
                if (bad) status <= ST_BAD_SIZE;
              end
              KIND_QUERY: begin
                if (bad) status <= ST_BAD_SIZE;
                else if (n_cw != 0) state <= S_GR_F;
              end
              KIND_MOVE: begin
                if (bad) status <= ST_BAD_SIZE;
                else state <= (n_cw != 0) ? S_OV_F : S_SW;
              end
              default: ;
            endcase
          end
        end
        S_OV_F: state <= S_OV_E;
        S_OV_E: begin
          if (ov_x && ov_y) begin
            status <= ST_OVERLAP;
            state  <= S_DONE;
          end else if (last) begin
            state <= S_SW;
          end else begin
            i     <= i + CW'(1);
            state <= S_OV_F;
          end
        end
        S_GR_F: state <= S_GR_E;
        S_GR_E: begin
          if (feet && ov_x) begin
            gr    <= 1'b1;
            state <= S_DONE;
          end else if (last) begin
            state <= S_DONE;
          end else begin
            i     <= i + CW'(1);
            state <= S_GR_F;
          end
        end
        S_SW: begin
          if ((s == SW'(MAX_SWEEPS)) || ((rx == 0) && (ry == 0))) begin
            state <= S_DONE;
          end else begin
            found <= 1'b0;
            best  <= T_ONE;
            {ff, fc, fle, fri, cf, cc, cle, cri} <= '0;
            i     <= '0;
            state <= (n_cw != 0) ? S_FETCH : S_MUL_X;
          end
        end
        S_FETCH: state <= S_XA;
        S_XA: begin
          if (rx != 0) begin
            state <= S_XW1;
          end else if (ov_x) begin
            xe    <= T_MIN;
            xl    <= T_MAX;
            state <= S_YA;
          end else if (last) begin
            state <= S_MUL_X;
          end else begin
            i     <= i + CW'(1);
            state <= S_FETCH;
          end
        end
        S_XW1: begin
          if (div_done) begin
            tmp_a <= div_q;
            state <= S_XW2;
          end
        end
        S_XW2: begin
          if (div_done) begin
            xe    <= (tmp_a < div_q) ? tmp_a : div_q;
            xl    <= (tmp_a < div_q) ? div_q : tmp_a;
            state <= S_YA;
          end
        end
        S_YA: begin
          if (ry != 0) begin
            state <= S_YW1;
          end else if (ov_y) begin
            ye    <= T_MIN;
            yl    <= T_MAX;
            state <= S_EVAL;
          end else if (last) begin
            state <= S_MUL_X;
          end else begin
            i     <= i + CW'(1);
            state <= S_FETCH;
          end
        end
        S_YW1: begin
          if (div_done) begin
            tmp_a <= div_q;
            state <= S_YW2;
          end
        end
        S_YW2: begin
          if (div_done) begin
            ye    <= (tmp_a < div_q) ? tmp_a : div_q;
            yl    <= (tmp_a < div_q) ? div_q : tmp_a;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!miss) begin
            if (take) begin
              found <= 1'b1;
              best  <= TW'(enc);
              if (corner) begin
                {ff, fc, fle, fri} <= '0;
                {cf, cc, cle, cri} <= {tf, tc, tl, tr};
              end else begin
                {ff, fc, fle, fri} <= {tf, tc, tl, tr};
                {cf, cc, cle, cri} <= '0;
              end
            end else if (merge) begin
              if (enc < best_e) best <= TW'(enc);
              if (corner) begin
                {cf, cc, cle, cri} <= {cf | tf, cc | tc, cle | tl, cri | tr};
              end else begin
                {ff, fc, fle, fri} <= {ff | tf, fc | tc, fle | tl, fri | tr};
              end
            end
          end
          if (last) begin
            state <= S_MUL_X;
          end else begin
            i     <= i + CW'(1);
            state <= S_FETCH;
          end
        end
        S_MUL_X: begin
          prod  <= mul_p;
          state <= S_ADV_X;
        end
        S_ADV_X: begin
          px    <= px + PW'(adv);
          rx    <= rx - adv;
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          prod  <= mul_p;
          state <= S_ADV_Y;
        end
        S_ADV_Y: begin
          py    <= py + PW'(adv);
          ry    <= ry - adv;
          state <= S_SW_END;
        end
        S_SW_END: begin
          if (ofl || oce) ry <= '0;
          if (olw || orw) rx <= '0;
          fl    <= fl | ofl;
          ce    <= ce | oce;
          lw    <= lw | olw;
          rw    <= rw | orw;
          s     <= s + SW'(1);
          state <= S_SW;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_data.status         <= status;
            out_data.new_x          <= sat24(px);
            out_data.new_y          <= sat24(py);
            out_data.hit_floor      <= fl;
            out_data.hit_ceiling    <= ce;
            out_data.hit_left_wall  <= lw;
            out_data.hit_right_wall <= rw;
            out_data.grounded       <= gr;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/sbcr_div.sv
// ----------------------------------------------------------------------------
// sbcr_div
// Iterative time divider: (num * 65536) / den, truncated toward zero and
// saturated to the signed Q2.16 time range. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbcr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [sbcr_pkg::PW-1:0]    num,
  input  logic signed [sbcr_pkg::DW-1:0]    den,
  output logic                              done,
  output logic signed [sbcr_pkg::TW-1:0]    quo
);
  import sbcr_pkg::*;

  localparam int KW = $clog2(QB);

  logic          busy;
  logic [KW-1:0] cnt;
  logic          neg;
  logic [DW-1:0] dmag;
  logic [DW-1:0] rem;
  logic [QB-1:0] nbits;
  logic [QB-1:0] q;

  logic [PW-1:0] nmag_c;
  logic [DW-1:0] dmag_c;
  logic [DW:0]   r2;
  logic [DW:0]   r2s;
  logic          qbit;
  logic [QB-1:0] qn;
  logic          sat;

  always_comb begin
    nmag_c = num[PW-1] ? PW'(-num) : PW'(num);
    dmag_c = den[DW-1] ? DW'(-den) : DW'(den);
    sat    = nmag_c >= PW'({dmag_c, 2'b00});
    r2     = {rem, nbits[QB-1]};
    qbit   = r2 >= {1'b0, dmag};
    r2s    = r2 - {1'b0, dmag};
    qn     = {q[QB-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem   <= qbit ? r2s[DW-1:0] : r2[DW-1:0];
        q     <= qn;
        nbits <= {nbits[QB-2:0], 1'b0};
        cnt   <= cnt + KW'(1);
        if (cnt == KW'(QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= neg ? -TW'({1'b0, qn}) : TW'({1'b0, qn});
        end
      end else if (start) begin
        neg  <= num[PW-1] ^ den[DW-1];
        dmag <= dmag_c;
        if (sat) begin
          quo  <= (num[PW-1] ^ den[DW-1]) ? T_MIN : T_MAX;
          done <= 1'b1;
        end else begin
          rem   <= nmag_c[DW+1:2];
          nbits <= {nmag_c[1:0], {(QB-2){1'b0}}};
          q     <= '0;
          cnt   <= '0;
          busy  <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/sbcr_store.sv
// ----------------------------------------------------------------------------
// sbcr_store
// Solid table: origin and extent of each solid, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbcr_store #(
  parameter int DEPTH = sbcr_pkg::DEF_MAX_SOLIDS,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  sbcr_pkg::solid_t        wdata,
  input  logic [AW-1:0]           raddr,
  output sbcr_pkg::solid_t        rdata
);
  import sbcr_pkg::*;

  solid_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
